/* rtl/erlt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// erlt_pkg
// Shared types and constants of the exclusive record lock table.
// ----------------------------------------------------------------------------
package erlt_pkg;

    localparam int LOCK_ENTRIES = 64;
    localparam int IDX_W        = $clog2(LOCK_ENTRIES);
    localparam int KEY_W        = 64;
    localparam int TX_W         = 16;
    localparam int STATUS_W     = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_HELD     = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_FULL     = 3'd3,
        ST_RELEASED = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } t_req_cmd;

    typedef struct packed {
        logic start;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage
`default_nettype wire

/* rtl/erlt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// erlt_ctrl
// Controller that sequences request capture, table scan and commit.
// ----------------------------------------------------------------------------
module erlt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    input  wire erlt_pkg::t_dp_sts i_sts,
    output erlt_pkg::t_dp_cmd     o_cmd
);
    import erlt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

/* rtl/erlt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// erlt_datapath
// Request registers, entry memory, valid bits, scan compare and result.
// ----------------------------------------------------------------------------
module erlt_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire erlt_pkg::t_dp_cmd      i_cmd,
    output erlt_pkg::t_dp_sts           o_sts,
    input  wire logic                   i_req_cmd,
    input  wire logic [15:0]            i_tx_id,
    input  wire logic [15:0]            i_table_id,
    input  wire logic [31:0]            i_page_number,
    input  wire logic [15:0]            i_slot_number,
    output logic [erlt_pkg::STATUS_W-1:0] o_status
);
    import erlt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_ENTRIES - 1);

    logic [KEY_W+TX_W-1:0] r_mem [LOCK_ENTRIES];
    logic [LOCK_ENTRIES-1:0] r_valid;

    t_req_cmd              r_req_cmd;
    logic [TX_W-1:0]       r_req_tx;
    logic [KEY_W-1:0]      r_req_key;

    logic                  r_rd_act;
    logic [IDX_W-1:0]      r_rd_addr;
    logic [KEY_W+TX_W-1:0] r_rd_data;
    logic                  r_cmp_en;
    logic [IDX_W-1:0]      r_cmp_idx;

    logic                  r_hit;
    logic                  r_hit_same;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_free;
    logic [IDX_W-1:0]      r_free_idx;

    logic                  w_match;
    t_status               w_status;
    t_status               r_status;

    assign w_match = r_valid[r_cmp_idx] && (r_rd_data[KEY_W+TX_W-1:TX_W] == r_req_key);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_cmd <= t_req_cmd'(i_req_cmd);
            r_req_tx  <= i_tx_id;
            r_req_key <= {i_table_id, i_page_number, i_slot_number};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_act) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
        if (i_cmd.commit && (r_req_cmd == CMD_ACQUIRE) && !r_hit && r_free) begin
            r_mem[r_free_idx] <= {r_req_key, r_req_tx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act <= 1'b0;
            r_cmp_en <= 1'b0;
            r_valid  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_rd_act <= 1'b1;
            end else if (r_rd_act && (r_rd_addr == LAST_IDX)) begin
                r_rd_act <= 1'b0;
            end
            r_cmp_en <= r_rd_act;
            if (i_cmd.commit) begin
                if (r_req_cmd == CMD_ACQUIRE) begin
                    if (!r_hit && r_free) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                end else if (r_hit && r_hit_same) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_addr <= '0;
        end else if (r_rd_act) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (r_rd_act) begin
            r_cmp_idx <= r_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_cmp_en) begin
            if (w_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_cmp_idx;
                r_hit_same <= (r_rd_data[TX_W-1:0] == r_req_tx);
            end
            if (!r_valid[r_cmp_idx] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    always_comb begin
        if (r_req_cmd == CMD_ACQUIRE) begin
            if (r_hit) begin
                w_status = r_hit_same ? ST_HELD : ST_CONFLICT;
            end else begin
                w_status = r_free ? ST_GRANTED : ST_FULL;
            end
        end else begin
            w_status = (r_hit && r_hit_same) ? ST_RELEASED : ST_IGNORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= w_status;
        end
    end

    assign o_sts.scan_done = r_cmp_en && (r_cmp_idx == LAST_IDX);
    assign o_status        = r_status;

endmodule
`default_nettype wire

/* rtl/exclusive_record_lock_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// exclusive_record_lock_table
// Exclusive lock table keyed by table, page and slot, one holder per entry.
// ----------------------------------------------------------------------------
// A request transaction (i_valid / o_ready) carries a command, the requesting
// transaction identifier and the record key. Each request produces exactly one
// status transaction on the result channel (o_valid / i_ready).
// The table holds 64 entries in a single-port memory, with a valid bit per
// entry in flip-flops. A request scans the memory one entry per cycle, and
// the block accepts no new request until the scan and commit of the
// previous one are done.
// A new request is accepted while the previous status still waits in the
// output register; its commit then waits until that status has been taken.
// Reset clears all valid bits, so the table starts empty at once, and drops
// any pending status.
// ----------------------------------------------------------------------------
module exclusive_record_lock_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_tx_id,
    input  wire logic [15:0] i_table_id,
    input  wire logic [31:0] i_page_number,
    input  wire logic [15:0] i_slot_number,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status
);
    import erlt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    erlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    erlt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_cmd     (i_cmd),
        .i_tx_id       (i_tx_id),
        .i_table_id    (i_table_id),
        .i_page_number (i_page_number),
        .i_slot_number (i_slot_number),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire
